/* rtl/sdlwd_pkg.sv */
package sdlwd_pkg;

    // Window geometry
    localparam int WINDOW_DEPTH = 1024;
    localparam int NUM_WIN      = 3;
    localparam int LAT_W        = 48;
    localparam int LENREG_W     = 11;
    localparam int STRIKE_W     = 8;
    localparam int LEN_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int POS_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = LEN_W + 2;
    localparam int CMP_W        = (LEN_W > LENREG_W) ? LEN_W : LENREG_W;
    localparam int ADDR_W       = $clog2(NUM_WIN * WINDOW_DEPTH);
    localparam int QUEUE_DEPTH  = 2;

    // Configuration port
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_RAND_THR   = 3'd1;
    localparam logic [2:0] REG_SEQ_THR    = 3'd2;
    localparam logic [2:0] REG_RAND_LEN   = 3'd3;
    localparam logic [2:0] REG_READ_LEN   = 3'd4;
    localparam logic [2:0] REG_WRITE_LEN  = 3'd5;
    localparam logic [2:0] REG_STRIKE_LIM = 3'd6;

    // Input codes
    localparam logic [1:0] CLS_RANDOM = 2'd0;
    localparam logic [1:0] CLS_SEQ    = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;

    // Window indexes
    localparam logic [1:0] WIN_RANDOM = 2'd0;
    localparam logic [1:0] WIN_READ   = 2'd1;
    localparam logic [1:0] WIN_WRITE  = 2'd2;

    typedef struct packed {
        logic [1:0]       io_class;
        logic [1:0]       op_kind;
        logic [LAT_W-1:0] latency;
    } t_in;

    typedef struct packed {
        logic slow_disk;
        logic sample_recorded;
    } t_out;

    typedef struct packed {
        logic                              enabled;
        logic [LAT_W-1:0]                  rand_thr;
        logic [LAT_W-1:0]                  seq_thr;
        logic [NUM_WIN-1:0][LENREG_W-1:0]  win_len;
        logic [STRIKE_W-1:0]               strike_limit;
    } t_cfg;

    // Classified item travelling from front to back
    typedef struct packed {
        logic [1:0]       win;
        logic             rec;
        logic             new_above;
        logic [LAT_W-1:0] latency;
    } t_work;

    // Window length as used: zero acts as one, clipped to the ring depth
    function automatic logic [LEN_W-1:0] eff_len(input logic [LENREG_W-1:0] r);
        logic [CMP_W-1:0] x;
        x = CMP_W'(r);
        if (x == '0) x = CMP_W'(1);
        if (x > CMP_W'(WINDOW_DEPTH)) x = CMP_W'(WINDOW_DEPTH);
        return LEN_W'(x);
    endfunction

    function automatic logic [LAT_W-1:0] win_thr(input t_cfg c, input logic [1:0] w);
        return (w == WIN_RANDOM) ? c.rand_thr : c.seq_thr;
    endfunction

endpackage

/* rtl/sdlwd_cfg.sv */
module sdlwd_cfg
    import sdlwd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enabled      <= 1'b0;
            r_cfg.rand_thr     <= '0;
            r_cfg.seq_thr      <= '0;
            r_cfg.win_len[0]   <= LENREG_W'(1024);
            r_cfg.win_len[1]   <= LENREG_W'(1024);
            r_cfg.win_len[2]   <= LENREG_W'(1024);
            r_cfg.strike_limit <= STRIKE_W'(3);
        end else if (wr_en) begin
            case (reg_idx)
                REG_ENABLE:     r_cfg.enabled      <= pwdata[0];
                REG_RAND_THR:   r_cfg.rand_thr     <= pwdata[LAT_W-1:0];
                REG_SEQ_THR:    r_cfg.seq_thr      <= pwdata[LAT_W-1:0];
                REG_RAND_LEN:   r_cfg.win_len[0]   <= pwdata[LENREG_W-1:0];
                REG_READ_LEN:   r_cfg.win_len[1]   <= pwdata[LENREG_W-1:0];
                REG_WRITE_LEN:  r_cfg.win_len[2]   <= pwdata[LENREG_W-1:0];
                REG_STRIKE_LIM: r_cfg.strike_limit <= pwdata[STRIKE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_ENABLE:     prdata = PDATA_W'(r_cfg.enabled);
            REG_RAND_THR:   prdata = PDATA_W'(r_cfg.rand_thr);
            REG_SEQ_THR:    prdata = PDATA_W'(r_cfg.seq_thr);
            REG_RAND_LEN:   prdata = PDATA_W'(r_cfg.win_len[0]);
            REG_READ_LEN:   prdata = PDATA_W'(r_cfg.win_len[1]);
            REG_WRITE_LEN:  prdata = PDATA_W'(r_cfg.win_len[2]);
            REG_STRIKE_LIM: prdata = PDATA_W'(r_cfg.strike_limit);
            default:        prdata = '0;
        endcase
    end

endmodule

/* rtl/sdlwd_front.sv */
module sdlwd_front
    import sdlwd_pkg::*;
(
    input  t_cfg  i_cfg,
    input  logic  i_in_valid,
    input  t_in   i_in_data,
    output logic  o_in_stall,
    input  logic  i_q_full,
    output logic  o_push,
    output t_work o_push_data
);

    logic       rec;
    logic [1:0] win;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Sort the access into a window; anything unusable is marked not recorded
    always_comb begin
        rec = i_cfg.enabled && (i_in_data.latency != '0) &&
              ((i_in_data.io_class == CLS_RANDOM) ||
               ((i_in_data.io_class == CLS_SEQ) &&
                (i_in_data.op_kind inside {OP_READ, OP_WRITE})));
        if (!rec || i_in_data.io_class == CLS_RANDOM) begin
            win = WIN_RANDOM;
        end else if (i_in_data.op_kind == OP_READ) begin
            win = WIN_READ;
        end else begin
            win = WIN_WRITE;
        end
    end

    always_comb begin
        o_push_data.win       = win;
        o_push_data.rec       = rec;
        o_push_data.latency   = i_in_data.latency;
        o_push_data.new_above = i_in_data.latency > win_thr(i_cfg, win);
    end

endmodule

/* rtl/sdlwd_queue.sv */
module sdlwd_queue
    import sdlwd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_push_data,
    output logic  o_full,
    output logic  o_head_valid,
    output t_work o_head,
    input  logic  i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_work             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;

    assign o_full       = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rd_ptr];

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* rtl/sdlwd_back.sv */
module sdlwd_back
    import sdlwd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_head_valid,
    input  t_work i_head,
    output logic  o_pop,
    output logic  o_out_valid,
    output t_out  o_out_data,
    input  logic  i_out_stall
);

    // Ring memory, one region of WINDOW_DEPTH entries per window
    logic [LAT_W-1:0] mem [NUM_WIN * WINDOW_DEPTH];
    logic [LAT_W-1:0] r_rd_data;

    // Per-window bookkeeping
    logic [POS_W-1:0]    r_pos    [NUM_WIN];
    logic [LEN_W-1:0]    r_fill   [NUM_WIN];
    logic [CNT_W-1:0]    r_above  [NUM_WIN];
    logic [CNT_W-1:0]    r_below  [NUM_WIN];
    logic [STRIKE_W-1:0] r_strike [NUM_WIN];

    // Execute stage: item plus a snapshot of its window
    logic                r_ex_valid;
    t_work               r_ex_item;
    logic [POS_W-1:0]    r_ex_pos;
    logic [LEN_W-1:0]    r_ex_len;
    logic                r_ex_full;
    logic [ADDR_W-1:0]   r_ex_addr;
    logic [CNT_W-1:0]    r_ex_above;
    logic [CNT_W-1:0]    r_ex_below;
    logic [STRIKE_W-1:0] r_ex_strike;

    logic                r_out_valid;
    t_out                r_out;

    // Lookup stage signals
    logic                a_fire;
    logic [1:0]          a_win;
    logic [LEN_W-1:0]    a_len;
    logic [POS_W-1:0]    a_pos;
    logic                a_full;
    logic [ADDR_W-1:0]   a_addr;

    // Update stage signals
    logic                b_fire;
    logic                b_clear;
    logic                b_slow;
    logic [LEN_W-1:0]    pos_inc;
    logic [STRIKE_W-1:0] lim;
    logic [POS_W-1:0]    n_pos;
    logic [LEN_W-1:0]    n_fill;
    logic [CNT_W-1:0]    n_above;
    logic [CNT_W-1:0]    n_below;
    logic [STRIKE_W-1:0] n_strike;

    // Lookup: pick the slot, check for a full window, start the memory read
    always_comb begin
        a_win  = i_head.win;
        a_len  = eff_len(i_cfg.win_len[a_win]);
        a_pos  = r_pos[a_win];
        if (LEN_W'(a_pos) >= a_len) a_pos = '0;
        a_full = (r_fill[a_win] >= a_len);
        a_addr = ADDR_W'(a_win) * ADDR_W'(WINDOW_DEPTH) + ADDR_W'(a_pos);
    end

    assign a_fire = i_head_valid && !r_ex_valid;
    assign o_pop  = a_fire;
    assign b_fire = r_ex_valid && (!r_out_valid || !i_out_stall);

    // Update: evict, insert, then judge the full window
    always_comb begin
        n_above  = r_ex_above;
        n_below  = r_ex_below;
        n_strike = r_ex_strike;
        n_fill   = r_fill[r_ex_item.win];
        b_clear  = 1'b0;
        b_slow   = 1'b0;
        lim      = (i_cfg.strike_limit == '0) ? STRIKE_W'(1) : i_cfg.strike_limit;

        if (r_ex_full) begin
            if (r_rd_data > win_thr(i_cfg, r_ex_item.win)) begin
                if (n_above != '0) n_above = n_above - 1'b1;
            end else begin
                if (n_below != '0) n_below = n_below - 1'b1;
            end
            n_fill = r_ex_len - 1'b1;
        end

        pos_inc = LEN_W'(r_ex_pos) + 1'b1;
        n_pos   = (pos_inc >= r_ex_len) ? '0 : POS_W'(pos_inc);
        n_fill  = n_fill + 1'b1;

        if (r_ex_item.new_above) begin
            if (n_above != '1) n_above = n_above + 1'b1;
        end else begin
            if (n_below != '1) n_below = n_below + 1'b1;
        end

        if (n_fill >= r_ex_len) begin
            if (n_below < n_above) begin
                if (n_strike != '1) n_strike = n_strike + 1'b1;
                b_clear = 1'b1;
                n_above = '0;
                n_below = '0;
                n_fill  = '0;
                n_pos   = '0;
            end else begin
                n_strike = '0;
            end
            b_slow = (n_strike >= lim);
        end
    end

    // Control and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_WIN; i++) begin
                r_pos[i]    <= '0;
                r_fill[i]   <= '0;
                r_above[i]  <= '0;
                r_below[i]  <= '0;
                r_strike[i] <= '0;
            end
        end else begin
            if (a_fire) begin
                r_ex_valid <= 1'b1;
            end else if (b_fire) begin
                r_ex_valid <= 1'b0;
            end
            if (b_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (b_fire && r_ex_item.rec) begin
                r_pos[r_ex_item.win]    <= n_pos;
                r_fill[r_ex_item.win]   <= n_fill;
                r_above[r_ex_item.win]  <= n_above;
                r_below[r_ex_item.win]  <= n_below;
                r_strike[r_ex_item.win] <= n_strike;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_ex_item   <= i_head;
            r_ex_pos    <= a_pos;
            r_ex_len    <= a_len;
            r_ex_full   <= a_full;
            r_ex_addr   <= a_addr;
            r_ex_above  <= r_above[a_win];
            r_ex_below  <= r_below[a_win];
            r_ex_strike <= r_strike[a_win];
        end
        if (b_fire) begin
            r_out.slow_disk       <= r_ex_item.rec && b_slow;
            r_out.sample_recorded <= r_ex_item.rec;
        end
    end

    // Ring memory ports
    always_ff @(posedge i_clk) begin
        if (b_fire && r_ex_item.rec) begin
            mem[r_ex_addr] <= r_ex_item.latency;
        end
        if (a_fire) begin
            r_rd_data <= mem[a_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_out_from_ex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_ex_valid))
        else $error("result appeared without an item in the update stage");

    a_slow_recorded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.slow_disk) |-> o_out_data.sample_recorded)
        else $error("slow reported for an item that was not recorded");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_fire && r_ex_item.rec && b_clear) |=>
            (r_fill[$past(r_ex_item.win)] == '0) && (r_pos[$past(r_ex_item.win)] == '0))
        else $error("struck window was not emptied");

    a_ex_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ex_valid && !b_fire) |=> (r_ex_valid && $stable(r_ex_item)))
        else $error("update stage item lost while output was stalled");
`endif

endmodule

/* rtl/slow_disk_latency_window_detector.sv */
// Slow disk detector: each accepted completion (class, op, latency) yields exactly one
// result. Random, sequential-read and sequential-write accesses each feed their own ring
// of recent latencies; when a full window holds more samples above its threshold than
// at or below it, that window's strike count rises and the window empties, and the result
// flags slow once strikes reach strike_limit. Disabled checking, zero latency and other
// classes or ops are passed through as not slow and not recorded. The update engine reads
// the evicted entry from the ring memory in its lookup step, then updates counts and
// writes the new latency back through its single write port in its update step; it
// takes no new item until the previous one has left the update step. A result passes
// through the queue, execute and output registers. A two-entry queue sits between the
// classifier and the engine, and a registered output lets a new item be taken while a
// result waits. Ring entries are never read before they are written, so no clearing
// pass follows reset. Configuration is written over the APB port at byte address 8*index;
// the user must write it only while the block is idle; the block does not enforce this.
module slow_disk_latency_window_detector
    import sdlwd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in                i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out               o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg  cfg;
    logic  q_push;
    t_work q_push_data;
    logic  q_full;
    logic  q_head_valid;
    t_work q_head;
    logic  q_pop;

    sdlwd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sdlwd_front u_front (
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    sdlwd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_data  (q_push_data),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (q_head),
        .i_pop        (q_pop)
    );

    sdlwd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule
